// File: rtl/core/lrd_pkg.sv
// shared types and constants for the ranged random draw block
package lrd_pkg;

  // data path width of seed, bounds and result
  localparam int unsigned DataW = 32;

  // generator constants
  localparam logic [DataW-1:0] LcgMul      = 32'd214013;
  localparam logic [DataW-1:0] LcgAdd      = 32'd2531011;
  localparam int unsigned      TemperShift = 15;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // action codes of an input word
  localparam logic ActLoad = 1'b0;
  localparam logic ActDraw = 1'b1;

  // one classified word as it travels from front to back
  typedef struct packed {
    logic             is_draw;
    logic [DataW-1:0] operand;     // new seed on a load, low bound on a draw
    logic [DataW-1:0] span;        // high - low + 1, wrapped
    logic             full_range;  // span wrapped to zero
  } lrd_entry_t;

  // front stage status
  typedef struct packed {
    logic valid;
    logic push;
  } lrd_front_stat_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } lrd_queue_stat_t;

endpackage

// File: rtl/core/lrd_front.sv
// front stage: accepts input words, classifies them and computes the span
module lrd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [lrd_pkg::DataW-1:0] in_seed_value,
  input  logic [lrd_pkg::DataW-1:0] in_low_bound,
  input  logic [lrd_pkg::DataW-1:0] in_high_bound,
  input  lrd_pkg::lrd_queue_stat_t  q_stat,
  output lrd_pkg::lrd_entry_t       push_entry,
  output lrd_pkg::lrd_front_stat_t  front_stat
);

  logic                  front_valid_r;
  logic                  front_valid_nxt;
  lrd_pkg::lrd_entry_t   entry_r;
  lrd_pkg::lrd_entry_t   entry_nxt;
  logic                  accept;
  logic                  push;
  logic [lrd_pkg::DataW-1:0] span;

  // handshake: hold while the queue cannot take the staged word
  assign push     = front_valid_r && !q_stat.full;
  assign in_stall = front_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;

  // classify the incoming word
  assign span = in_high_bound - in_low_bound + lrd_pkg::DataW'(1);

  always_comb begin
    entry_nxt            = entry_r;
    entry_nxt.is_draw    = (in_action == lrd_pkg::ActDraw);
    entry_nxt.operand    = (in_action == lrd_pkg::ActDraw) ? in_low_bound : in_seed_value;
    entry_nxt.span       = span;
    entry_nxt.full_range = (span == '0);
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign push_entry       = entry_r;
  assign front_stat.valid = front_valid_r;
  assign front_stat.push  = push;

endmodule

// File: rtl/core/lrd_queue.sv
// short queue between front and back
module lrd_queue #(
  parameter int unsigned DEPTH = lrd_pkg::QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  lrd_pkg::lrd_entry_t      push_entry,
  input  logic                     pop,
  output lrd_pkg::lrd_entry_t      head_entry,
  output lrd_pkg::lrd_queue_stat_t q_stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lrd_pkg::lrd_entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry   = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == CntW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// File: rtl/core/lrd_back.sv
// back end: seed register, generator step, serial modulo and result register
module lrd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lrd_pkg::lrd_entry_t       head_entry,
  input  lrd_pkg::lrd_queue_stat_t  q_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lrd_pkg::DataW-1:0] out_drawn_value
);

  localparam int unsigned W     = lrd_pkg::DataW;
  localparam int unsigned StepW = $clog2(W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_t;

  back_state_t         state_r;
  back_state_t         state_nxt;
  logic [W-1:0]        seed_r;
  logic [W-1:0]        prod_r;
  logic [W-1:0]        dvd_r;
  logic [W-1:0]        rem_r;
  logic [W-1:0]        res_r;
  logic [StepW-1:0]    step_r;
  lrd_pkg::lrd_entry_t cur_r;
  logic                out_valid_r;
  logic [W-1:0]        out_data_r;

  logic [W-1:0]        prod_full;
  logic [W-1:0]        seed_sum;
  logic [W-1:0]        tempered;
  logic [W:0]          rem_shift;
  logic [W:0]          rem_diff;
  logic [W-1:0]        rem_new;
  logic                last_step;
  logic                out_free;

  // generator step: multiply (low half only), then add and temper
  assign prod_full = seed_r * lrd_pkg::LcgMul;
  assign seed_sum  = prod_r + lrd_pkg::LcgAdd;
  assign tempered  = seed_sum ^ (seed_sum >> lrd_pkg::TemperShift);

  // one restoring step of the modulo
  assign rem_shift = {rem_r, dvd_r[W-1]};
  assign rem_diff  = rem_shift - {1'b0, cur_r.span};
  assign rem_new   = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
  assign last_step = (step_r == StepW'(W - 1));

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && !q_stat.empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && head_entry.is_draw) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = cur_r.full_range ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && !head_entry.is_draw) begin
        seed_r <= head_entry.operand;
      end else if (state_r == ST_ADD) begin
        seed_r <= seed_sum;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_entry;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_full;
    end
    if (state_r == ST_ADD) begin
      dvd_r  <= tempered;
      rem_r  <= '0;
      step_r <= '0;
      res_r  <= tempered;
    end
    if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[W-2:0], 1'b0};
      rem_r  <= rem_new;
      step_r <= step_r + StepW'(1);
      if (last_step) begin
        res_r <= cur_r.operand + rem_new;
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_data_r;

endmodule

// File: rtl/core/lcg_ranged_random_draw.sv
// ranged random draw: 32-bit congruential generator with bounded result
// a load word only replaces the seed as the back end pops it; a draw passes through
// pop, multiply, add and temper, 32 restoring modulo steps and result write,
// skipping the modulo steps when the span covers the full 32-bit range
// a draw is registered in the front stage and queued before the back end works on it
// synchronous active-low reset clears the seed to zero and empties all stages
module lcg_ranged_random_draw #(
  parameter int unsigned QUEUE_DEPTH = lrd_pkg::QueueDepth
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [lrd_pkg::DataW-1:0] in_seed_value,
  input  logic [lrd_pkg::DataW-1:0] in_low_bound,
  input  logic [lrd_pkg::DataW-1:0] in_high_bound,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lrd_pkg::DataW-1:0] out_drawn_value
);

  lrd_pkg::lrd_entry_t      push_entry;
  lrd_pkg::lrd_entry_t      head_entry;
  lrd_pkg::lrd_front_stat_t front_stat;
  lrd_pkg::lrd_queue_stat_t q_stat;
  logic                     pop;

  // front stage
  lrd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_seed_value (in_seed_value),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .q_stat        (q_stat),
    .push_entry    (push_entry),
    .front_stat    (front_stat)
  );

  // queue
  lrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_stat.push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  // back end
  lrd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_entry      (head_entry),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.push |-> !q_stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (front_stat.valid && q_stat.full))
    else $error("input stalled without a full queue");

endmodule

// File: tb/lrd_draw_checker.sv
`timescale 1ns / 1ps
// result checker for the ranged random draw: tracks the seed and compares every drawn word
module lrd_draw_checker
  import lrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_action,
  input  logic [DataW-1:0] in_seed_value,
  input  logic [DataW-1:0] in_low_bound,
  input  logic [DataW-1:0] in_high_bound,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [DataW-1:0] out_drawn_value,
  output int unsigned      err_cnt,
  output int unsigned      outstanding,
  output int unsigned      checked_cnt
);

  localparam int unsigned MaxReports = 20;

  logic [DataW-1:0] gen_seed;
  logic [DataW-1:0] expected_draws[$];

  // step the generator, temper, and reduce into [lo, hi] with wrapped span
  function automatic logic [DataW-1:0] draw_next(input logic [DataW-1:0] lo,
                                                 input logic [DataW-1:0] hi);
    logic [DataW-1:0] span;
    logic [DataW-1:0] mixed;
    span     = hi - lo + 1;
    gen_seed = gen_seed * LcgMul + LcgAdd;
    mixed    = gen_seed ^ (gen_seed >> TemperShift);
    // zero span means the whole 32-bit range: no reduction, no offset
    if (span == '0) begin
      return mixed;
    end
    return lo + (mixed % span);
  endfunction

  always @(posedge clk) begin : watch
    logic [DataW-1:0] want;
    if (!rst_n) begin
      gen_seed = '0;
      expected_draws.delete();
      err_cnt     = 0;
      checked_cnt = 0;
    end else begin
      // handshake outputs of the block must never be unknown
      if ($isunknown(out_valid) || (in_valid && $isunknown(in_stall))) begin
        err_cnt++;
        if (err_cnt <= MaxReports) begin
          $display("%0t: unknown handshake, expected 0/1, got out_valid=%b in_stall=%b",
                   $time, out_valid, in_stall);
        end
      end
      // result side first: a word taken at this edge cannot be answered yet
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("%0t: unexpected drawn word, expected none, got %h",
                     $time, out_drawn_value);
          end
        end else begin
          want = expected_draws.pop_front();
          checked_cnt++;
          if (out_drawn_value !== want) begin
            err_cnt++;
            if (err_cnt <= MaxReports) begin
              $display("%0t: drawn_value mismatch, expected %h, got %h",
                       $time, want, out_drawn_value);
            end
          end
        end
      end
      // input side: a load replaces the seed, a draw queues its answer
      if (in_valid && !in_stall) begin
        if (in_action == ActDraw) begin
          expected_draws.push_back(draw_next(in_low_bound, in_high_bound));
        end else begin
          gen_seed = in_seed_value;
        end
      end
    end
    outstanding <= expected_draws.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// top of the ranged random draw testbench: clock, reset, word stimulus and verdict
module tb;
  import lrd_pkg::*;

  localparam int unsigned RandWords  = 1650;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 60;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic             in_action     = ActLoad;
  logic [DataW-1:0] in_seed_value = '0;
  logic [DataW-1:0] in_low_bound  = '0;
  logic [DataW-1:0] in_high_bound = '0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [DataW-1:0] out_drawn_value;

  int unsigned err_cnt;
  int unsigned outstanding;
  int unsigned checked_cnt;

  int unsigned cycle_cnt = 0;
  int          burst_left = 1;
  int unsigned load_cnt = 0;
  int unsigned draw_cnt = 0;
  int unsigned full_cnt = 0;

  int stall_mode  = 0;
  int phase_left  = 0;
  int stall_run   = 0;

  lcg_ranged_random_draw uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_seed_value   (in_seed_value),
    .in_low_bound    (in_low_bound),
    .in_high_bound   (in_high_bound),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value)
  );

  lrd_draw_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_seed_value   (in_seed_value),
    .in_low_bound    (in_low_bound),
    .in_high_bound   (in_high_bound),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value),
    .err_cnt         (err_cnt),
    .outstanding     (outstanding),
    .checked_cnt     (checked_cnt)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: run timed out with %0d draws outstanding", $time, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern: phases of no stall, light, heavy and long runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      phase_left = 0;
      stall_run  = 0;
    end else begin
      if (phase_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(100, 400);
      end
      phase_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run = $urandom_range(5, 40);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // present one word until taken, then idle per burst pattern or drain
  task automatic send_word(input logic act, input logic [DataW-1:0] seed_val,
                           input logic [DataW-1:0] lo, input logic [DataW-1:0] hi,
                           input bit drain);
    int gap;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_seed_value <= seed_val;
    in_low_bound  <= lo;
    in_high_bound <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ActDraw) begin
      draw_cnt++;
      if (hi - lo + 32'd1 == '0) full_cnt++;
    end else begin
      load_cnt++;
    end
    burst_left--;
    if (drain) begin
      // hold off until every queued draw has come back
      in_valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end else if (burst_left <= 0) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(10, 40);
        default:       gap = $urandom_range(1, 8);
      endcase
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // bound pairs: wide, narrow, single, whole range, signed, power-of-two, near-full
  task automatic pick_bounds(output logic [DataW-1:0] lo, output logic [DataW-1:0] hi);
    int unsigned k;
    lo = $urandom();
    case ($urandom_range(0, 7))
      0: hi = $urandom();
      1: hi = lo + $urandom_range(0, 15);
      2: hi = lo;
      3: hi = lo - 32'd1;
      4: begin
        lo = 32'd0 - $urandom_range(0, 1000);
        hi = $urandom_range(0, 1000);
      end
      5: begin
        k  = $urandom_range(1, 31);
        hi = lo + ((32'd1 << k) - 32'd1);
      end
      6: hi = lo - 32'd1 - $urandom_range(1, 8);
      default: begin
        lo = '0;
        hi = 32'h7FFF_FFFF >> $urandom_range(0, 30);
      end
    endcase
  endtask

  initial begin : stimulus
    logic             act;
    logic [DataW-1:0] seed_val;
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: seed zero after reset, then extremes of bounds and seeds
    send_word(ActDraw, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_word(ActDraw, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 0);
    send_word(ActLoad, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000, 0);
    send_word(ActDraw, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 0);
    send_word(ActDraw, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    // signed full range and a signed window of -100..100
    send_word(ActDraw, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_word(ActDraw, 32'h0000_0000, 32'hFFFF_FF9C, 32'h0000_0064, 0);
    // reversed bounds wrap the span instead of flagging
    send_word(ActDraw, 32'h0000_0000, 32'h0000_000A, 32'h0000_0005, 0);
    send_word(ActDraw, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 0);
    send_word(ActDraw, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
    send_word(ActDraw, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFE, 0);
    send_word(ActDraw, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_word(ActDraw, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    // back-to-back loads, the later one wins, then draws right behind
    send_word(ActLoad, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(ActLoad, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_word(ActDraw, 32'h5555_5555, 32'h0000_0000, 32'h0000_0001, 0);
    send_word(ActDraw, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_word(ActLoad, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0000, 0);
    send_word(ActDraw, 32'h0000_0000, 32'h0000_0003, 32'h0000_0003, 1);

    // random words, mostly draws, with a few full drains on the way
    for (int i = 0; i < RandWords; i++) begin
      act      = ($urandom_range(0, 99) < 15) ? ActLoad : ActDraw;
      seed_val = $urandom();
      pick_bounds(lo, hi);
      send_word(act, seed_val, lo, hi, (i == 500) || (i == 1100) || (i == RandWords - 1));
    end

    repeat (TailCycles) @(posedge clk);
    $display("sent %0d seed loads and %0d draws (%0d over the whole 32-bit range)",
             load_cnt, draw_cnt, full_cnt);
    $display("checked %0d drawn words, %0d failures", checked_cnt, err_cnt);
    if (err_cnt == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lrd_pkg.sv
rtl/core/lrd_front.sv
rtl/core/lrd_queue.sv
rtl/core/lrd_back.sv
rtl/core/lcg_ranged_random_draw.sv
tb/lrd_draw_checker.sv
tb/tb.sv
